/* design/assert_macros.svh */
// Assertion macros used by the RTL files (included by swnh_ctrl).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define AST_CHK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define AST_RAW(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define AST_CHK(lbl, clk, rstn, prop)
`define AST_RAW(lbl, clk, prop)
`endif
`endif

/* design/swnh_pkg.sv */
// Shared types and constants of the segment wall nearest hit block.
`default_nettype none
package swnh_pkg;
  localparam int MAX_WALLS = 512;
  localparam int WALL_AW = $clog2(MAX_WALLS);
  localparam int CNT_W = 10;
  localparam int NCNT_W = WALL_AW + 1;
  localparam int WALL_W = 128;
  localparam int DIV_STEPS = 32;
  localparam int DIVC_W = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    CFG_WALL_COUNT = 2'd0,
    CFG_PAR_THR    = 2'd1,
    CFG_MIN_MOVE   = 2'd2,
    CFG_UNUSED     = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    MUL_NONE, MUL_ABX_ABX, MUL_ABY_ABY, MUL_ABX_CDY, MUL_ABY_CDX, MUL_DX_CDY,
    MUL_DY_CDX, MUL_DX_ABY, MUL_DY_ABX, MUL_TQ_DX, MUL_TQ_DY, MUL_TQ_DZ
  } mul_sel_t;

  typedef enum logic [3:0] {
    ACC_NONE, ACC_LEN_LD, ACC_LEN_ADD, ACC_DEN_LD, ACC_DEN_SUB,
    ACC_NT_LD, ACC_NT_SUB, ACC_NU_LD, ACC_NU_SUB, ACC_OUT_X, ACC_OUT_Y, ACC_OUT_Z
  } acc_sel_t;

  typedef struct packed {
    logic               load_q;
    logic               wr_en;
    logic [WALL_AW-1:0] rd_addr;
    logic               load_w;
    mul_sel_t           mul;
    acc_sel_t           acc;
    logic               div_init;
    logic               div_step;
    logic               best_upd;
  } swnh_cmd_t;

  typedef struct packed {
    logic short_move;
    logic wall_ok;
    logic found;
  } swnh_sts_t;

  function automatic logic [66:0] abs67(input logic signed [66:0] v);
    abs67 = v[66] ? 67'(-v) : 67'(v);
  endfunction
endpackage
`default_nettype wire

/* design/swnh_ram.sv */
// Generic single-port-write, registered-read RAM.
`default_nettype none
module swnh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* design/swnh_ctrl.sv */
// Controller: issues wall writes and sequences the query over the wall table.
`default_nettype none
`include "assert_macros.svh"
module swnh_ctrl (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic                         in_func,
  input  wire logic [swnh_pkg::WALL_AW-1:0] in_wall_index,
  input  wire logic [swnh_pkg::CNT_W-1:0]   wall_count,
  input  wire swnh_pkg::swnh_sts_t          sts,
  output swnh_pkg::swnh_cmd_t               cmd,
  output logic                              busy,
  output logic                              out_valid
);
  typedef enum logic [4:0] {
    S_IDLE, S_L0, S_L1, S_L2, S_L3, S_RD, S_LW, S_M0, S_M1, S_M2, S_M3, S_M4,
    S_M5, S_M6, S_CHK, S_DIV, S_CMP, S_NEXT, S_I0, S_I1, S_I2, S_I3, S_DONE
  } state_t;

  state_t                          state_r, state_nxt;
  logic [swnh_pkg::WALL_AW-1:0]    idx_r, idx_nxt;
  logic [swnh_pkg::NCNT_W-1:0]     n_r, n_nxt;
  logic [swnh_pkg::DIVC_W-1:0]     dc_r, dc_nxt;
  logic                            done_r;
  logic                            accept;

  assign accept = start && (state_r == S_IDLE);
  assign busy = (state_r != S_IDLE);
  assign out_valid = done_r;

  always_comb begin
    state_nxt = state_r;
    idx_nxt = idx_r;
    n_nxt = n_r;
    dc_nxt = dc_r;
    cmd = '0;
    cmd.mul = swnh_pkg::MUL_NONE;
    cmd.acc = swnh_pkg::ACC_NONE;
    cmd.rd_addr = idx_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_func) begin
            cmd.load_q = 1'b1;
            state_nxt = S_L0;
          end else if (int'(in_wall_index) < swnh_pkg::MAX_WALLS) begin
            cmd.wr_en = 1'b1;
          end
        end
      end
      S_L0: begin
        cmd.mul = swnh_pkg::MUL_ABX_ABX;
        state_nxt = S_L1;
      end
      S_L1: begin
        cmd.mul = swnh_pkg::MUL_ABY_ABY;
        cmd.acc = swnh_pkg::ACC_LEN_LD;
        state_nxt = S_L2;
      end
      S_L2: begin
        cmd.acc = swnh_pkg::ACC_LEN_ADD;
        state_nxt = S_L3;
      end
      S_L3: begin
        idx_nxt = '0;
        if (int'(wall_count) > swnh_pkg::MAX_WALLS) begin
          n_nxt = swnh_pkg::NCNT_W'(swnh_pkg::MAX_WALLS);
        end else begin
          n_nxt = swnh_pkg::NCNT_W'(wall_count);
        end
        if (sts.short_move || wall_count == '0) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_RD;
        end
      end
      S_RD: state_nxt = S_LW;
      S_LW: begin
        cmd.load_w = 1'b1;
        state_nxt = S_M0;
      end
      S_M0: begin
        cmd.mul = swnh_pkg::MUL_ABX_CDY;
        state_nxt = S_M1;
      end
      S_M1: begin
        cmd.mul = swnh_pkg::MUL_ABY_CDX;
        cmd.acc = swnh_pkg::ACC_DEN_LD;
        state_nxt = S_M2;
      end
      S_M2: begin
        cmd.mul = swnh_pkg::MUL_DX_CDY;
        cmd.acc = swnh_pkg::ACC_DEN_SUB;
        state_nxt = S_M3;
      end
      S_M3: begin
        cmd.mul = swnh_pkg::MUL_DY_CDX;
        cmd.acc = swnh_pkg::ACC_NT_LD;
        state_nxt = S_M4;
      end
      S_M4: begin
        cmd.mul = swnh_pkg::MUL_DX_ABY;
        cmd.acc = swnh_pkg::ACC_NT_SUB;
        state_nxt = S_M5;
      end
      S_M5: begin
        cmd.mul = swnh_pkg::MUL_DY_ABX;
        cmd.acc = swnh_pkg::ACC_NU_LD;
        state_nxt = S_M6;
      end
      S_M6: begin
        cmd.acc = swnh_pkg::ACC_NU_SUB;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        dc_nxt = '0;
        if (sts.wall_ok) begin
          cmd.div_init = 1'b1;
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_NEXT;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        dc_nxt = dc_r + 1'b1;
        if (dc_r == swnh_pkg::DIVC_W'(swnh_pkg::DIV_STEPS - 1)) begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        cmd.best_upd = 1'b1;
        state_nxt = S_NEXT;
      end
      S_NEXT: begin
        if ({1'b0, idx_r} + 1'b1 == n_r) begin
          state_nxt = sts.found ? S_I0 : S_DONE;
        end else begin
          idx_nxt = idx_r + 1'b1;
          state_nxt = S_RD;
        end
      end
      S_I0: begin
        cmd.mul = swnh_pkg::MUL_TQ_DX;
        state_nxt = S_I1;
      end
      S_I1: begin
        cmd.mul = swnh_pkg::MUL_TQ_DY;
        cmd.acc = swnh_pkg::ACC_OUT_X;
        state_nxt = S_I2;
      end
      S_I2: begin
        cmd.mul = swnh_pkg::MUL_TQ_DZ;
        cmd.acc = swnh_pkg::ACC_OUT_Y;
        state_nxt = S_I3;
      end
      S_I3: begin
        cmd.acc = swnh_pkg::ACC_OUT_Z;
        state_nxt = S_DONE;
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r <= '0;
      n_r <= '0;
      dc_r <= '0;
      done_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r <= idx_nxt;
      n_r <= n_nxt;
      dc_r <= dc_nxt;
      done_r <= (state_r == S_DONE);
    end
  end

  `AST_CHK(a_query_busy, clk, rst_n, (accept && in_func) |=> busy)
  `AST_CHK(a_write_idle, clk, rst_n, (accept && !in_func) |=> !busy)
  `AST_CHK(a_strobe_pulse, clk, rst_n, out_valid |-> (!$past(out_valid) && !busy))
endmodule
`default_nettype wire

/* design/swnh_dp.sv */
// Datapath: wall table, shared multiplier, accumulators, divider and result words.
`default_nettype none
module swnh_dp (
  input  wire logic                         clk,
  input  wire swnh_pkg::swnh_cmd_t          cmd,
  output swnh_pkg::swnh_sts_t               sts,
  input  wire logic [swnh_pkg::WALL_AW-1:0] in_wall_index,
  input  wire logic signed [31:0]           in_wall_a_x,
  input  wire logic signed [31:0]           in_wall_a_y,
  input  wire logic signed [31:0]           in_wall_b_x,
  input  wire logic signed [31:0]           in_wall_b_y,
  input  wire logic signed [31:0]           in_seg_a_x,
  input  wire logic signed [31:0]           in_seg_a_y,
  input  wire logic signed [31:0]           in_seg_a_z,
  input  wire logic signed [31:0]           in_seg_b_x,
  input  wire logic signed [31:0]           in_seg_b_y,
  input  wire logic signed [31:0]           in_seg_b_z,
  input  wire logic [31:0]                  parallel_threshold,
  input  wire logic [31:0]                  min_move_sq,
  output logic                              out_hit,
  output logic signed [31:0]                out_hit_x,
  output logic signed [31:0]                out_hit_y,
  output logic signed [31:0]                out_hit_z
);
  logic [swnh_pkg::WALL_W-1:0] rdata;
  logic signed [31:0] ax_r, ay_r, az_r, wax, way, wbx, wby;
  logic signed [32:0] abx_r, aby_r, abz_r, cdx_r, cdy_r, dx_r, dy_r;
  logic signed [33:0] ma, mb;
  logic signed [67:0] prod_r;
  logic signed [66:0] len_r, den_r, nt_r, nu_r, p67;
  logic [66:0] aden, ant, anu, dvs_r;
  logic [67:0] rem_r, sh;
  logic [32:0] q_r, best_r;
  logic found_r, hit_r, neg_sel;
  logic signed [31:0] hx_r, hy_r, hz_r, base;
  logic [65:0] rnd;
  logic [31:0] off;
  logic [31:0] res;

  swnh_ram #(.WIDTH(swnh_pkg::WALL_W), .DEPTH(swnh_pkg::MAX_WALLS)) u_ram (
    .clk  (clk),
    .we   (cmd.wr_en),
    .waddr(in_wall_index),
    .wdata({in_wall_a_x, in_wall_a_y, in_wall_b_x, in_wall_b_y}),
    .raddr(cmd.rd_addr),
    .rdata(rdata)
  );

  assign {wax, way, wbx, wby} = rdata;

  always_comb begin
    case (cmd.mul)
      swnh_pkg::MUL_ABX_ABX: begin ma = 34'(abx_r); mb = 34'(abx_r); end
      swnh_pkg::MUL_ABY_ABY: begin ma = 34'(aby_r); mb = 34'(aby_r); end
      swnh_pkg::MUL_ABX_CDY: begin ma = 34'(abx_r); mb = 34'(cdy_r); end
      swnh_pkg::MUL_ABY_CDX: begin ma = 34'(aby_r); mb = 34'(cdx_r); end
      swnh_pkg::MUL_DX_CDY:  begin ma = 34'(dx_r);  mb = 34'(cdy_r); end
      swnh_pkg::MUL_DY_CDX:  begin ma = 34'(dy_r);  mb = 34'(cdx_r); end
      swnh_pkg::MUL_DX_ABY:  begin ma = 34'(dx_r);  mb = 34'(aby_r); end
      swnh_pkg::MUL_DY_ABX:  begin ma = 34'(dy_r);  mb = 34'(abx_r); end
      swnh_pkg::MUL_TQ_DX: begin
        ma = {1'b0, best_r};
        mb = {1'b0, abx_r[32] ? 33'(-abx_r) : 33'(abx_r)};
      end
      swnh_pkg::MUL_TQ_DY: begin
        ma = {1'b0, best_r};
        mb = {1'b0, aby_r[32] ? 33'(-aby_r) : 33'(aby_r)};
      end
      swnh_pkg::MUL_TQ_DZ: begin
        ma = {1'b0, best_r};
        mb = {1'b0, abz_r[32] ? 33'(-abz_r) : 33'(abz_r)};
      end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  assign p67 = prod_r[66:0];
  assign aden = swnh_pkg::abs67(den_r);
  assign ant = swnh_pkg::abs67(nt_r);
  assign anu = swnh_pkg::abs67(nu_r);

  // t and u in [0,1], denominator not near zero
  always_comb begin
    sts.wall_ok = (den_r != '0) && (aden >= {35'd0, parallel_threshold})
      && (nt_r == '0 || nt_r[66] == den_r[66]) && (ant <= aden)
      && (nu_r == '0 || nu_r[66] == den_r[66]) && (anu <= aden);
    sts.short_move = $unsigned(len_r) < {35'd0, min_move_sq};
    sts.found = found_r;
  end

  assign sh = {rem_r[66:0], 1'b0};
  assign rnd = prod_r[65:0] + 66'h0_8000_0000;
  assign off = rnd[63:32];

  always_comb begin
    case (cmd.acc)
      swnh_pkg::ACC_OUT_X: begin base = ax_r; neg_sel = abx_r[32]; end
      swnh_pkg::ACC_OUT_Y: begin base = ay_r; neg_sel = aby_r[32]; end
      default: begin base = az_r; neg_sel = abz_r[32]; end
    endcase
    res = neg_sel ? 32'($unsigned(base) - off) : 32'($unsigned(base) + off);
  end

  always_ff @(posedge clk) begin
    prod_r <= ma * mb;
    if (cmd.load_q) begin
      ax_r <= in_seg_a_x;
      ay_r <= in_seg_a_y;
      az_r <= in_seg_a_z;
      abx_r <= 33'(in_seg_b_x) - 33'(in_seg_a_x);
      aby_r <= 33'(in_seg_b_y) - 33'(in_seg_a_y);
      abz_r <= 33'(in_seg_b_z) - 33'(in_seg_a_z);
      hx_r <= in_seg_a_x;
      hy_r <= in_seg_a_y;
      hz_r <= in_seg_a_z;
      hit_r <= 1'b0;
      found_r <= 1'b0;
    end
    if (cmd.load_w) begin
      cdx_r <= 33'(wbx) - 33'(wax);
      cdy_r <= 33'(wby) - 33'(way);
      dx_r <= 33'(wax) - 33'(ax_r);
      dy_r <= 33'(way) - 33'(ay_r);
    end
    case (cmd.acc)
      swnh_pkg::ACC_LEN_LD:  len_r <= p67;
      swnh_pkg::ACC_LEN_ADD: len_r <= len_r + p67;
      swnh_pkg::ACC_DEN_LD:  den_r <= p67;
      swnh_pkg::ACC_DEN_SUB: den_r <= den_r - p67;
      swnh_pkg::ACC_NT_LD:   nt_r <= p67;
      swnh_pkg::ACC_NT_SUB:  nt_r <= nt_r - p67;
      swnh_pkg::ACC_NU_LD:   nu_r <= p67;
      swnh_pkg::ACC_NU_SUB:  nu_r <= nu_r - p67;
      swnh_pkg::ACC_OUT_X:   hx_r <= res;
      swnh_pkg::ACC_OUT_Y:   hy_r <= res;
      swnh_pkg::ACC_OUT_Z: begin
        hz_r <= res;
        hit_r <= 1'b1;
      end
      default: ;
    endcase
    if (cmd.div_init) begin
      dvs_r <= aden;
      if (ant >= aden) begin
        rem_r <= {1'b0, ant - aden};
        q_r <= 33'd1;
      end else begin
        rem_r <= {1'b0, ant};
        q_r <= 33'd0;
      end
    end
    if (cmd.div_step) begin
      if (sh >= {1'b0, dvs_r}) begin
        rem_r <= sh - {1'b0, dvs_r};
        q_r <= {q_r[31:0], 1'b1};
      end else begin
        rem_r <= sh;
        q_r <= {q_r[31:0], 1'b0};
      end
    end
    if (cmd.best_upd && (!found_r || q_r < best_r)) begin
      best_r <= q_r;
      found_r <= 1'b1;
    end
  end

  assign out_hit = hit_r;
  assign out_hit_x = hx_r;
  assign out_hit_y = hy_r;
  assign out_hit_z = hz_r;
endmodule
`default_nettype wire

/* design/segment_wall_nearest_hit.sv */
// Top level of the segment wall nearest hit block.
// Usage: raise start with the in_ fields while busy is low to hand over one word.
// in_func low writes one wall into slot in_wall_index; busy stays low and no
// result follows. in_func high runs a query: busy rises and the block walks
// walls 0 to min(wall_count,512)-1, reading one wall from the table per pass
// and sharing one 34x34 multiplier for all cross products.
// Each wall that is crossed runs the bit-serial divider that quantizes t;
// the hit on the nearest wall is then interpolated. A short movement or a
// zero wall count answers without walking the table.
// One query at a time; the next word is taken after busy falls.
// The result is on out_hit and out_hit_x/y/z for one cycle with out_valid;
// the receiver cannot stall it. Configuration: cfg_we writes cfg_data into
// register cfg_index; the user must write it only while idle, as the block
// itself does not enforce this.
// Reset (rst_n low, synchronous) clears control and loads wall_count 0 and
// both thresholds 1; the wall table is not cleared and must be written first.
`default_nettype none
module segment_wall_nearest_hit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               in_func,
  input  wire logic [8:0]         in_wall_index,
  input  wire logic signed [31:0] in_wall_a_x,
  input  wire logic signed [31:0] in_wall_a_y,
  input  wire logic signed [31:0] in_wall_b_x,
  input  wire logic signed [31:0] in_wall_b_y,
  input  wire logic signed [31:0] in_seg_a_x,
  input  wire logic signed [31:0] in_seg_a_y,
  input  wire logic signed [31:0] in_seg_a_z,
  input  wire logic signed [31:0] in_seg_b_x,
  input  wire logic signed [31:0] in_seg_b_y,
  input  wire logic signed [31:0] in_seg_b_z,
  output logic                    out_valid,
  output logic                    out_hit,
  output logic signed [31:0]      out_hit_x,
  output logic signed [31:0]      out_hit_y,
  output logic signed [31:0]      out_hit_z,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);
  logic [swnh_pkg::CNT_W-1:0] wall_count_r;
  logic [31:0]                par_thr_r, min_move_r;
  swnh_pkg::swnh_cmd_t        cmd;
  swnh_pkg::swnh_sts_t        sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wall_count_r <= '0;
      par_thr_r <= 32'd1;
      min_move_r <= 32'd1;
    end else if (cfg_we) begin
      unique case (swnh_pkg::cfg_idx_t'(cfg_index))
        swnh_pkg::CFG_WALL_COUNT: wall_count_r <= cfg_data[swnh_pkg::CNT_W-1:0];
        swnh_pkg::CFG_PAR_THR:    par_thr_r <= cfg_data;
        swnh_pkg::CFG_MIN_MOVE:   min_move_r <= cfg_data;
        default: ;
      endcase
    end
  end

  swnh_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_func      (in_func),
    .in_wall_index(in_wall_index),
    .wall_count   (wall_count_r),
    .sts          (sts),
    .cmd          (cmd),
    .busy         (busy),
    .out_valid    (out_valid)
  );

  swnh_dp u_dp (
    .clk               (clk),
    .cmd               (cmd),
    .sts               (sts),
    .in_wall_index     (in_wall_index),
    .in_wall_a_x       (in_wall_a_x),
    .in_wall_a_y       (in_wall_a_y),
    .in_wall_b_x       (in_wall_b_x),
    .in_wall_b_y       (in_wall_b_y),
    .in_seg_a_x        (in_seg_a_x),
    .in_seg_a_y        (in_seg_a_y),
    .in_seg_a_z        (in_seg_a_z),
    .in_seg_b_x        (in_seg_b_x),
    .in_seg_b_y        (in_seg_b_y),
    .in_seg_b_z        (in_seg_b_z),
    .parallel_threshold(par_thr_r),
    .min_move_sq       (min_move_r),
    .out_hit           (out_hit),
    .out_hit_x         (out_hit_x),
    .out_hit_y         (out_hit_y),
    .out_hit_z         (out_hit_z)
  );
endmodule
`default_nettype wire
